// ----- rtl/ctag_pkg.sv -----
package ctag_pkg;

    // Geometry limits and field widths.
    localparam int MAX_DIMS = 4;
    localparam int EXT_REGS = 4;
    localparam int LANES    = (MAX_DIMS < EXT_REGS) ? MAX_DIMS : EXT_REGS;
    localparam int LANE_W   = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int EXT_IDX_W = $clog2(EXT_REGS);

    localparam int DIMC_W = 3;
    localparam int SIDE_W = 8;
    localparam int EXT_W  = 16;
    localparam int OFS_W  = 31;
    localparam int RUN_W  = 16;
    localparam int STAT_W = 2;

    // Configuration port geometry.
    localparam int ADDR_W = 5;
    localparam int APB_W  = 32;

    // Stream payload widths.
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 80;
    localparam int M_USER_W = 2;

    // Register map, by word index.
    typedef enum logic [2:0] {
        REG_DIM_COUNT   = 3'd0,
        REG_CELL_SIDE   = 3'd1,
        REG_TYPE_SIZE   = 3'd2,
        REG_EXTENT_0    = 3'd3,
        REG_EXTENT_1    = 3'd4,
        REG_EXTENT_2    = 3'd5,
        REG_EXTENT_3    = 3'd6,
        REG_BLOCK_BYTES = 3'd7
    } reg_idx_t;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        ST_OK           = 2'd0,
        ST_BAD_GEOM     = 2'd1,
        ST_LEN_MISMATCH = 2'd2,
        ST_TOO_SMALL    = 2'd3
    } status_t;

    // Register contents seen by the geometry unit.
    typedef struct packed {
        logic [DIMC_W-1:0]                 dim_count;
        logic [SIDE_W-1:0]                 cell_side;
        logic [SIDE_W-1:0]                 type_size;
        logic [EXT_REGS-1:0][EXT_W-1:0]    extent;
        logic [OFS_W-1:0]                  block_bytes;
    } cfg_t;

    // Per-lane constants of the walk. Lane 0 is the fastest dimension.
    typedef struct packed {
        status_t                           status;
        logic [LANES-1:0][EXT_W-1:0]       cells_m1;
        logic [LANES-1:0][SIDE_W-1:0]      edge_m1;
        logic [SIDE_W-1:0]                 side_m1;
        logic [LANES-1:0][OFS_W-1:0]       stride;
        logic [LANES-1:0][OFS_W-1:0]       cell_stride;
        logic [RUN_W-1:0]                  run_full;
        logic [RUN_W-1:0]                  run_edge;
    } geom_t;

endpackage

// ----- rtl/nd_cell_tiling_address_gen.sv -----
// Cell tiling address generator.
// Each transfer on the slave stream (s_tdata bit 0: restart) asks for the
// next copy run that reorders a row-major block into cube cells. Each
// transfer on the master stream returns one run: its byte offset in the
// block, its byte offset in the packed cell stream and its length, with
// m_tlast on the final run of the block or on an error, and the status code
// in m_tuser. Restart, or any request after reset, a register write, an
// error or the final run, starts again at the first run.
// Throughput is one run per cycle unless the geometry unit is busy or the skid
// register is full: all counters and offsets advance by additions in the same
// cycle that takes the request, and each result is registered before it is sent.
// After reset and after every register write the geometry unit checks the
// registers and derives the per-dimension constants; s_tready stays low while
// it runs a load step, 16 division steps and a finishing step.
// Results sit in an output register backed by a skid register, so one more
// request is taken while the receiver stalls; then s_tready drops until the
// receiver takes a result. The user must write registers over the APB port
// only while no request is pending; the block itself does not enforce this.
module nd_cell_tiling_address_gen
    import ctag_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // Configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [APB_W-1:0]    pwdata,
    output logic [APB_W-1:0]    prdata,
    output logic                pready,
    // Request stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [0] restart, [7:1] zero
    // Run stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // [30:0] block_offset, [61:31] packed_offset,
                                           // [77:62] run_bytes, [79:78] zero
    output logic                m_tlast,   // last_run
    output logic [M_USER_W-1:0] m_tuser    // [1:0] status
);

    typedef struct packed {
        logic [OFS_W-1:0] block_offset;
        logic [OFS_W-1:0] packed_offset;
        logic [RUN_W-1:0] run_bytes;
        logic             last_run;
        status_t          status;
    } result_t;

    // Configuration registers.
    logic [DIMC_W-1:0]              dim_count_reg;
    logic [SIDE_W-1:0]              cell_side_reg;
    logic [SIDE_W-1:0]              type_size_reg;
    logic [EXT_REGS-1:0][EXT_W-1:0] extent_reg;
    logic [OFS_W-1:0]               block_bytes_reg;
    cfg_t                           cfg;
    logic                           cfg_wr;
    reg_idx_t                       reg_idx;

    // Geometry unit.
    logic                           geom_busy;
    geom_t                          geom;

    // Walk state.
    logic                           active_reg, active_next;
    logic [LANES-1:0][EXT_W-1:0]    cell_reg, cell_next;
    logic [LANES-1:0][SIDE_W-1:0]   inner_reg, inner_next;
    logic [LANES-1:0][OFS_W-1:0]    part_reg, part_next;
    logic [LANES-1:0][OFS_W-1:0]    base_reg, base_next;
    logic [OFS_W-1:0]               packed_reg, packed_next;

    // Output register and skid register.
    logic                           out_valid_reg, out_valid_next;
    result_t                        out_data_reg, out_data_next;
    logic                           skid_valid_reg, skid_valid_next;
    result_t                        skid_data_reg, skid_data_next;

    // Working values of the walk.
    logic                           s_fire;
    logic                           m_fire;
    logic                           start;
    logic                           err;
    logic                           done;
    logic [LANES-1:0][EXT_W-1:0]    cell_e, cell_adv;
    logic [LANES-1:0][SIDE_W-1:0]   inner_e, inner_adv;
    logic [LANES-1:0][OFS_W-1:0]    part_e, part_adv;
    logic [LANES-1:0][OFS_W-1:0]    base_e, base_adv;
    logic [LANES-1:0]               edge_hit;
    logic [LANES-1:0][SIDE_W-1:0]   clip_m1;
    logic [OFS_W-1:0]               packed_e;
    logic [OFS_W-1:0]               offs;
    logic [RUN_W-1:0]               run;
    result_t                        res;

    // Register file access.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

    always_comb
    begin
        unique case (reg_idx)
            REG_DIM_COUNT:   prdata = APB_W'(dim_count_reg);
            REG_CELL_SIDE:   prdata = APB_W'(cell_side_reg);
            REG_TYPE_SIZE:   prdata = APB_W'(type_size_reg);
            REG_EXTENT_0:    prdata = APB_W'(extent_reg[0]);
            REG_EXTENT_1:    prdata = APB_W'(extent_reg[1]);
            REG_EXTENT_2:    prdata = APB_W'(extent_reg[2]);
            REG_EXTENT_3:    prdata = APB_W'(extent_reg[3]);
            REG_BLOCK_BYTES: prdata = APB_W'(block_bytes_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_count_reg   <= DIMC_W'(1);
            cell_side_reg   <= SIDE_W'(1);
            type_size_reg   <= SIDE_W'(1);
            extent_reg      <= {EXT_REGS{EXT_W'(1)}};
            block_bytes_reg <= OFS_W'(1);
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_DIM_COUNT:   dim_count_reg   <= pwdata[DIMC_W-1:0];
                REG_CELL_SIDE:   cell_side_reg   <= pwdata[SIDE_W-1:0];
                REG_TYPE_SIZE:   type_size_reg   <= pwdata[SIDE_W-1:0];
                REG_EXTENT_0:    extent_reg[0]   <= pwdata[EXT_W-1:0];
                REG_EXTENT_1:    extent_reg[1]   <= pwdata[EXT_W-1:0];
                REG_EXTENT_2:    extent_reg[2]   <= pwdata[EXT_W-1:0];
                REG_EXTENT_3:    extent_reg[3]   <= pwdata[EXT_W-1:0];
                REG_BLOCK_BYTES: block_bytes_reg <= pwdata[OFS_W-1:0];
                default:         block_bytes_reg <= block_bytes_reg;
            endcase
        end
    end

    always_comb
    begin
        cfg.dim_count   = dim_count_reg;
        cfg.cell_side   = cell_side_reg;
        cfg.type_size   = type_size_reg;
        cfg.extent      = extent_reg;
        cfg.block_bytes = block_bytes_reg;
    end

    ctag_geom u_geom (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (cfg_wr),
        .cfg   (cfg),
        .busy  (geom_busy),
        .geom  (geom)
    );

    // Handshakes.
    assign s_tready = !geom_busy && !skid_valid_reg;
    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = out_valid_reg && m_tready;

    // Current run and the advance of the nested counters.
    always_comb
    begin
        logic carry;

        start    = s_tdata[0] || !active_reg;
        err      = start && (geom.status != ST_OK);
        packed_e = start ? '0 : packed_reg;
        for (int r = 0; r < LANES; r++)
        begin
            cell_e[r]   = start ? '0 : cell_reg[r];
            inner_e[r]  = start ? '0 : inner_reg[r];
            part_e[r]   = start ? '0 : part_reg[r];
            base_e[r]   = start ? '0 : base_reg[r];
            edge_hit[r] = (cell_e[r] == geom.cells_m1[r]);
            clip_m1[r]  = edge_hit[r] ? geom.edge_m1[r] : geom.side_m1;
        end

        offs = '0;
        for (int r = 0; r < LANES; r++)
            offs = offs + part_e[r];
        run = edge_hit[0] ? geom.run_edge : geom.run_full;

        // Rows inside the cell; lane 0 is the run itself and never steps.
        cell_adv  = cell_e;
        inner_adv = inner_e;
        part_adv  = part_e;
        base_adv  = base_e;
        carry     = 1'b1;
        for (int r = 1; r < LANES; r++)
        begin
            if (carry)
            begin
                if (inner_e[r] == clip_m1[r])
                begin
                    inner_adv[r] = '0;
                    part_adv[r]  = base_e[r];
                end
                else
                begin
                    inner_adv[r] = inner_e[r] + 1'b1;
                    part_adv[r]  = part_e[r] + geom.stride[r];
                    carry        = 1'b0;
                end
            end
        end

        // Next cell once every row of this one is done.
        if (carry)
        begin
            for (int r = 0; r < LANES; r++)
            begin
                if (carry)
                begin
                    if (edge_hit[r])
                    begin
                        cell_adv[r] = '0;
                        base_adv[r] = '0;
                    end
                    else
                    begin
                        cell_adv[r] = cell_e[r] + 1'b1;
                        base_adv[r] = base_e[r] + geom.cell_stride[r];
                        carry       = 1'b0;
                    end
                end
            end
            for (int r = 0; r < LANES; r++)
                part_adv[r] = base_adv[r];
        end
        done = carry;

        if (err)
        begin
            res.block_offset  = '0;
            res.packed_offset = '0;
            res.run_bytes     = '0;
            res.last_run      = 1'b1;
            res.status        = geom.status;
        end
        else
        begin
            res.block_offset  = offs;
            res.packed_offset = packed_e;
            res.run_bytes     = run;
            res.last_run      = done;
            res.status        = ST_OK;
        end
    end

    // Walk state update.
    always_comb
    begin
        active_next = active_reg;
        cell_next   = cell_reg;
        inner_next  = inner_reg;
        part_next   = part_reg;
        base_next   = base_reg;
        packed_next = packed_reg;
        if (cfg_wr)
            active_next = 1'b0;
        else if (s_fire)
        begin
            if (err)
                active_next = 1'b0;
            else
            begin
                active_next = !done;
                cell_next   = cell_adv;
                inner_next  = inner_adv;
                part_next   = part_adv;
                base_next   = base_adv;
                packed_next = packed_e + OFS_W'(run);
            end
        end
    end

    // Output register with a skid register behind it.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (m_fire)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (s_fire)
        begin
            if (!out_valid_reg || m_fire)
            begin
                out_data_next  = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = res;
                skid_valid_next = 1'b1;
            end
        end
        else if (m_fire)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            cell_reg       <= '0;
            inner_reg      <= '0;
            part_reg       <= '0;
            base_reg       <= '0;
            packed_reg     <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg     <= active_next;
            cell_reg       <= cell_next;
            inner_reg      <= inner_next;
            part_reg       <= part_next;
            base_reg       <= base_next;
            packed_reg     <= packed_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    // Master stream.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_DATA_W - 2 * OFS_W - RUN_W)'(0), out_data_reg.run_bytes,
                       out_data_reg.packed_offset, out_data_reg.block_offset};
    assign m_tlast  = out_data_reg.last_run;
    assign m_tuser  = M_USER_W'(out_data_reg.status);

endmodule

// ----- rtl/ctag_geom.sv -----
// Geometry unit: checks the registers and derives the per-lane walk constants.
// It restarts after reset and after every register write, and runs a load
// step, EXT_W division steps and a finishing step.
module ctag_geom
    import ctag_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  load,
    input  cfg_t  cfg,
    output logic  busy,
    output geom_t geom
);

    localparam int STEP_W = $clog2(EXT_W);
    localparam int PROD_W = OFS_W + EXT_W;
    localparam int CSTR_W = OFS_W + SIDE_W;
    localparam int CUBE_W = SIDE_W * (LANES + 1);

    typedef enum logic [3:0] {
        G_LOAD = 4'b0001,
        G_RUN  = 4'b0010,
        G_FIN  = 4'b0100,
        G_DONE = 4'b1000
    } gstate_t;

    gstate_t                      state_reg, state_next;
    logic [STEP_W-1:0]            step_reg, step_next;
    status_t                      status_reg, status_next;
    logic [PROD_W-1:0]            prod_reg, prod_next;
    logic [CUBE_W-1:0]            cube_reg, cube_next;
    logic [OFS_W-1:0]             cur_s_reg, cur_s_next;
    logic [LANES-1:0][EXT_W-1:0]  dvd_reg, dvd_next;
    logic [LANES-1:0][SIDE_W-1:0] prem_reg, prem_next;
    logic [LANES-1:0][OFS_W-1:0]  stride_reg, stride_next;
    logic [LANES-1:0][OFS_W-1:0]  cstride_reg, cstride_next;
    logic [LANES-1:0][EXT_W-1:0]  cells_m1_reg, cells_m1_next;
    logic [LANES-1:0][SIDE_W-1:0] edge_m1_reg, edge_m1_next;
    logic [RUN_W-1:0]             run_full_reg, run_full_next;
    logic [RUN_W-1:0]             run_edge_reg, run_edge_next;

    logic [LANES-1:0][EXT_W-1:0]  lane_ext;
    logic [STEP_W-1:0]            n_step;
    logic [EXT_W-1:0]             step_ext;
    logic [LANE_W-1:0]            lane_sel;

    // Extent of each lane, fastest dimension first; unused lanes count one.
    always_comb
    begin
        for (int r = 0; r < LANES; r++)
        begin
            if (r < int'(cfg.dim_count))
                lane_ext[r] = cfg.extent[EXT_IDX_W'(int'(cfg.dim_count) - 1 - r)];
            else
                lane_ext[r] = EXT_W'(1);
        end
    end

    assign n_step   = STEP_W'(cfg.dim_count);
    assign step_ext = cfg.extent[step_reg[EXT_IDX_W-1:0]];
    assign lane_sel = step_reg[LANE_W-1:0];

    // Sequencer: checks, strides and divisions share the step counter.
    always_comb
    begin
        logic [SIDE_W:0]  trial;
        logic             nz;
        logic [SIDE_W-1:0] last_w;

        state_next    = state_reg;
        step_next     = step_reg;
        status_next   = status_reg;
        prod_next     = prod_reg;
        cube_next     = cube_reg;
        cur_s_next    = cur_s_reg;
        dvd_next      = dvd_reg;
        prem_next     = prem_reg;
        stride_next   = stride_reg;
        cstride_next  = cstride_reg;
        cells_m1_next = cells_m1_reg;
        edge_m1_next  = edge_m1_reg;
        run_full_next = run_full_reg;
        run_edge_next = run_edge_reg;
        trial         = '0;
        nz            = 1'b0;
        last_w        = '0;

        unique case (state_reg)
            G_LOAD:
            begin
                if (cfg.dim_count == '0 || int'(cfg.dim_count) > LANES ||
                    cfg.cell_side == '0 || cfg.type_size == '0)
                    status_next = ST_BAD_GEOM;
                else
                    status_next = ST_OK;
                prod_next  = PROD_W'(cfg.type_size);
                cube_next  = CUBE_W'(cfg.type_size);
                cur_s_next = OFS_W'(cfg.type_size);
                for (int r = 0; r < LANES; r++)
                begin
                    dvd_next[r]  = lane_ext[r];
                    prem_next[r] = '0;
                end
                step_next  = '0;
                state_next = G_RUN;
            end
            G_RUN:
            begin
                // One restoring division step per lane: extent by cell side.
                for (int r = 0; r < LANES; r++)
                begin
                    trial = {prem_reg[r], dvd_reg[r][EXT_W-1]};
                    if (trial >= {1'b0, cfg.cell_side})
                    begin
                        prem_next[r] = SIDE_W'(trial - {1'b0, cfg.cell_side});
                        dvd_next[r]  = {dvd_reg[r][EXT_W-2:0], 1'b1};
                    end
                    else
                    begin
                        prem_next[r] = trial[SIDE_W-1:0];
                        dvd_next[r]  = {dvd_reg[r][EXT_W-2:0], 1'b0};
                    end
                end

                // Length checks, slowest dimension first; the first error sticks.
                if (status_reg == ST_OK)
                begin
                    priority if (step_reg != '0 && step_reg <= n_step &&
                                 prod_reg > PROD_W'(cfg.block_bytes))
                        status_next = ST_LEN_MISMATCH;
                    else if (step_reg < n_step && step_ext == '0)
                        status_next = ST_BAD_GEOM;
                    else if (step_reg == STEP_W'(LANES + 1) &&
                             prod_reg != PROD_W'(cfg.block_bytes))
                        status_next = ST_LEN_MISMATCH;
                    else if (step_reg == STEP_W'(LANES + 1) &&
                             CUBE_W'(cfg.block_bytes) < cube_reg)
                        status_next = ST_TOO_SMALL;
                    else
                        status_next = status_reg;

                    if (step_reg < n_step)
                    begin
                        prod_next = PROD_W'(prod_reg[OFS_W-1:0]) * PROD_W'(step_ext);
                        cube_next = CUBE_W'(cube_reg[CUBE_W-SIDE_W-1:0]) *
                                    CUBE_W'(cfg.cell_side);
                    end
                end

                // Byte strides per lane and their cell-sized multiples.
                if (step_reg < STEP_W'(LANES))
                begin
                    stride_next[lane_sel]  = cur_s_reg;
                    cstride_next[lane_sel] = OFS_W'(CSTR_W'(cur_s_reg) *
                                                    CSTR_W'(cfg.cell_side));
                    cur_s_next = OFS_W'(PROD_W'(cur_s_reg) * PROD_W'(lane_ext[lane_sel]));
                end

                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(EXT_W - 1))
                    state_next = G_FIN;
            end
            G_FIN:
            begin
                for (int r = 0; r < LANES; r++)
                begin
                    nz = (prem_reg[r] != '0);
                    cells_m1_next[r] = nz ? dvd_reg[r] : dvd_reg[r] - 1'b1;
                    edge_m1_next[r]  = nz ? prem_reg[r] - 1'b1 : cfg.cell_side - 1'b1;
                end
                last_w        = (prem_reg[0] != '0) ? prem_reg[0] : cfg.cell_side;
                run_full_next = RUN_W'(cfg.cell_side) * RUN_W'(cfg.type_size);
                run_edge_next = RUN_W'(last_w) * RUN_W'(cfg.type_size);
                state_next    = G_DONE;
            end
            G_DONE:
            begin
                state_next = G_DONE;
            end
            default:
            begin
                state_next = G_LOAD;
            end
        endcase

        if (load)
            state_next = G_LOAD;
    end

    // Sequencer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= G_LOAD;
        else
            state_reg <= state_next;
    end

    // Working and result registers.
    always_ff @(posedge clk)
    begin
        step_reg     <= step_next;
        status_reg   <= status_next;
        prod_reg     <= prod_next;
        cube_reg     <= cube_next;
        cur_s_reg    <= cur_s_next;
        dvd_reg      <= dvd_next;
        prem_reg     <= prem_next;
        stride_reg   <= stride_next;
        cstride_reg  <= cstride_next;
        cells_m1_reg <= cells_m1_next;
        edge_m1_reg  <= edge_m1_next;
        run_full_reg <= run_full_next;
        run_edge_reg <= run_edge_next;
    end

    assign busy = (state_reg != G_DONE);

    always_comb
    begin
        geom.status      = status_reg;
        geom.cells_m1    = cells_m1_reg;
        geom.edge_m1     = edge_m1_reg;
        geom.side_m1     = cfg.cell_side - 1'b1;
        geom.stride      = stride_reg;
        geom.cell_stride = cstride_reg;
        geom.run_full    = run_full_reg;
        geom.run_edge    = run_edge_reg;
    end

endmodule

// ----- rtl/ctag_checker.sv -----
// Port-level checks of the cell tiling address generator.
module ctag_checker
    import ctag_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                psel,
    input logic                penable,
    input logic                pwrite,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic                m_tlast,
    input logic [M_USER_W-1:0] m_tuser
);

    // A stalled run holds its payload.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
                                  $stable(m_tlast) && $stable(m_tuser))
        else $error("run payload changed while stalled");

    // An error result carries no offsets or length and ends the block.
    a_error_form: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != '0 |-> m_tlast && m_tdata == '0)
        else $error("error result is not an empty last run");

    // A good run always moves at least one byte.
    a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == '0 |-> m_tdata[2*OFS_W+RUN_W-1:2*OFS_W] != '0)
        else $error("good run with zero length");

    // A register write sends the geometry unit back to work.
    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite |=> !s_tready)
        else $error("request taken right after a register write");

endmodule

bind nd_cell_tiling_address_gen ctag_checker u_ctag_checker (.*);

// ----- bench/tb_nd_cell_tiling_address_gen.sv -----
module tb_nd_cell_tiling_address_gen
    import ctag_pkg::*;
;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [APB_W-1:0]    pwdata;
    logic [APB_W-1:0]    prdata;
    logic                pready;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;   // [0] restart, [7:1] zero
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;   // [30:0] block_offset, [61:31] packed_offset,
                                    // [77:62] run_bytes, [79:78] zero
    logic                m_tlast;   // last_run
    logic [M_USER_W-1:0] m_tuser;   // [1:0] status

    // One copy run as the block should report it.
    typedef struct {
        bit [OFS_W-1:0] block_offset;
        bit [OFS_W-1:0] packed_offset;
        bit [RUN_W-1:0] run_bytes;
        bit             last_run;
        status_t        status;
    } run_t;

    // Tracks the register file and the walk through the cells, and holds the
    // runs that are still owed by the block.
    class run_tracker;
        int unsigned dims, side, tsize, blen;
        int unsigned ext [EXT_REGS];
        int unsigned ccoord [EXT_REGS];
        int unsigned icoord [EXT_REGS];
        int unsigned ncells [EXT_REGS];
        int unsigned ppos, corigin;
        bit          walking;
        run_t        owed_runs [$];
        int          mismatches;

        function new();
            int d;
            dims = 1;
            side = 1;
            tsize = 1;
            blen = 1;
            for (d = 0; d < EXT_REGS; d++)
            begin
                ext[d] = 1;
                ccoord[d] = 0;
                icoord[d] = 0;
                ncells[d] = 0;
            end
            ppos = 0;
            corigin = 0;
            walking = 1'b0;
            mismatches = 0;
        endfunction

        // Any register write ends the walk in progress.
        function void set_reg(reg_idx_t idx, bit [31:0] value);
            case (idx)
                REG_DIM_COUNT:   dims = value & 32'h7;
                REG_CELL_SIDE:   side = value & 32'hFF;
                REG_TYPE_SIZE:   tsize = value & 32'hFF;
                REG_EXTENT_0:    ext[0] = value & 32'hFFFF;
                REG_EXTENT_1:    ext[1] = value & 32'hFFFF;
                REG_EXTENT_2:    ext[2] = value & 32'hFFFF;
                REG_EXTENT_3:    ext[3] = value & 32'hFFFF;
                REG_BLOCK_BYTES: blen = value & 32'h7FFF_FFFF;
                default: ;
            endcase
            walking = 1'b0;
        endfunction

        // Geometry check, in the order the block applies it.
        function status_t geometry_status();
            longint unsigned prod;
            longint unsigned cell_bytes;
            int d;
            if (dims < 1 || dims > MAX_DIMS || dims > EXT_REGS)
                return ST_BAD_GEOM;
            if (side == 0 || tsize == 0)
                return ST_BAD_GEOM;
            prod = tsize;
            for (d = 0; d < dims; d++)
            begin
                if (ext[d] == 0)
                    return ST_BAD_GEOM;
                prod = prod * ext[d];
                if (prod > blen)
                    return ST_LEN_MISMATCH;
            end
            if (prod != blen)
                return ST_LEN_MISMATCH;
            cell_bytes = tsize;
            for (d = 0; d < dims; d++)
                cell_bytes = cell_bytes * side;
            if (blen < cell_bytes)
                return ST_TOO_SMALL;
            return ST_OK;
        endfunction

        // Cell width along one dimension, clipped on the upper edge.
        function int unsigned edge_len(int d);
            int unsigned rem;
            rem = ext[d] % side;
            if (rem != 0 && ccoord[d] + 1 == ncells[d])
                return rem;
            return side;
        endfunction

        // Element index of the origin of the current cell.
        function int unsigned cell_base();
            longint unsigned elem;
            longint unsigned stride;
            int d;
            elem = 0;
            stride = 1;
            for (d = dims - 1; d >= 0; d--)
            begin
                elem = elem + longint'(ccoord[d]) * side * stride;
                stride = stride * ext[d];
            end
            return 32'(elem & 64'h7FFF_FFFF);
        endfunction

        // An accepted request: work out the run it produces.
        function void note_request(bit restart);
            run_t            r;
            status_t         st;
            longint unsigned row;
            longint unsigned stride;
            int unsigned     width;
            int unsigned     v;
            bit              carry;
            int              d;
            r.block_offset = '0;
            r.packed_offset = '0;
            r.run_bytes = '0;
            r.last_run = 1'b0;
            r.status = ST_OK;
            if (restart || !walking)
            begin
                st = geometry_status();
                if (st != ST_OK)
                begin
                    walking = 1'b0;
                    r.last_run = 1'b1;
                    r.status = st;
                    owed_runs.push_back(r);
                    return;
                end
                for (d = 0; d < EXT_REGS; d++)
                begin
                    ccoord[d] = 0;
                    icoord[d] = 0;
                    ncells[d] = 0;
                end
                for (d = 0; d < dims; d++)
                    ncells[d] = (ext[d] + side - 1) / side;
                ppos = 0;
                corigin = cell_base();
                walking = 1'b1;
            end

            // Offsets of the current row inside the current cell.
            row = corigin;
            stride = ext[dims-1];
            for (d = dims - 1; d > 0; d--)
            begin
                row = row + longint'(icoord[d-1]) * stride;
                stride = stride * ext[d-1];
            end
            width = edge_len(dims - 1) * tsize;
            r.block_offset = OFS_W'(row * tsize);
            r.packed_offset = OFS_W'(ppos);
            r.run_bytes = RUN_W'(width);
            ppos = (ppos + width) & 32'h7FFF_FFFF;

            // Step the row counters, then the cell counters on a carry.
            carry = 1'b1;
            for (d = dims - 1; d > 0 && carry; d--)
            begin
                v = icoord[d-1] + 1;
                if (v < edge_len(d - 1))
                begin
                    icoord[d-1] = v;
                    carry = 1'b0;
                end
                else
                    icoord[d-1] = 0;
            end
            if (carry)
            begin
                for (d = dims; d > 0 && carry; d--)
                begin
                    v = ccoord[d-1] + 1;
                    if (v < ncells[d-1])
                    begin
                        ccoord[d-1] = v;
                        carry = 1'b0;
                    end
                    else
                        ccoord[d-1] = 0;
                end
                if (carry)
                begin
                    r.last_run = 1'b1;
                    walking = 1'b0;
                end
                else
                    corigin = cell_base();
            end
            owed_runs.push_back(r);
        endfunction

        function int pending();
            return owed_runs.size();
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        // A run seen on the output: compare it with the oldest one owed.
        task check_run(logic [OFS_W-1:0] blk, logic [OFS_W-1:0] pkd,
                       logic [RUN_W-1:0] len, logic lst, logic [STAT_W-1:0] st);
            run_t want;
            if (owed_runs.size() == 0)
            begin
                report($sformatf("run with no request behind it, block offset %0d", blk));
                return;
            end
            want = owed_runs.pop_front();
            if (blk !== want.block_offset)
                report($sformatf("block_offset %0d, want %0d", blk, want.block_offset));
            if (pkd !== want.packed_offset)
                report($sformatf("packed_offset %0d, want %0d", pkd, want.packed_offset));
            if (len !== want.run_bytes)
                report($sformatf("run_bytes %0d, want %0d", len, want.run_bytes));
            if (lst !== want.last_run)
                report($sformatf("last_run %0b, want %0b", lst, want.last_run));
            if (st !== want.status)
                report($sformatf("status %0d, want %0d", st, want.status));
        endtask
    endclass

    run_tracker runs;
    bit [31:0]  cfg_words [8];
    bit         tx_idle_en;
    bit         rx_idle_en;
    bit         hold_req;

    nd_cell_tiling_address_gen dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard limit on the run time.
    initial
    begin
        #2000000;
        $display("nd_cell_tiling_address_gen regression: fail");
        $finish;
    end

    // Run receiver: checks every transfer and stalls in random bursts, or for
    // one long stretch when asked.
    initial
    begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                runs.check_run(m_tdata[30:0], m_tdata[61:31], m_tdata[77:62],
                               m_tlast, m_tuser);
            if (hold_req)
            begin
                hold_left = 120;
                hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (rx_idle_en && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(1, 13) - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // One register write: setup cycle, then access cycle until pready.
    task automatic write_reg(reg_idx_t idx, bit [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        runs.set_reg(idx, value);
    endtask

    // Waits for every owed run, then writes the whole register set.
    task automatic program_regs();
        int i;
        while (runs.pending() != 0)
            @(posedge clk);
        for (i = 0; i < 8; i++)
            write_reg(reg_idx_t'(i), cfg_words[i]);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_cfg(int unsigned dims, int unsigned side, int unsigned tsize,
                           int unsigned e0, int unsigned e1, int unsigned e2,
                           int unsigned e3, int unsigned blen);
        cfg_words[REG_DIM_COUNT] = dims;
        cfg_words[REG_CELL_SIDE] = side;
        cfg_words[REG_TYPE_SIZE] = tsize;
        cfg_words[REG_EXTENT_0] = e0;
        cfg_words[REG_EXTENT_1] = e1;
        cfg_words[REG_EXTENT_2] = e2;
        cfg_words[REG_EXTENT_3] = e3;
        cfg_words[REG_BLOCK_BYTES] = blen;
        program_regs();
    endtask

    // Small random geometry, mostly consistent, sometimes broken on purpose.
    task automatic pick_random_geometry();
        int unsigned dims, side, tsize, blen, max_ext;
        int unsigned ext [EXT_REGS];
        bit [31:0]   keep [8] = '{32'h7, 32'hFF, 32'hFF, 32'hFFFF, 32'hFFFF,
                                  32'hFFFF, 32'hFFFF, 32'h7FFF_FFFF};
        int          d;
        dims = $urandom_range(1, 4);
        max_ext = (dims == 1) ? 40 : (dims == 2) ? 12 : (dims == 3) ? 6 : 4;
        side = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 5);
        tsize = $urandom_range(0, 1) ? $urandom_range(1, 8) : $urandom_range(1, 255);
        blen = tsize;
        for (d = 0; d < EXT_REGS; d++)
        begin
            ext[d] = (d < dims) ? $urandom_range(1, max_ext) : $urandom_range(0, 65535);
            if (d < dims)
                blen = blen * ext[d];
        end
        case ($urandom_range(0, 11))
            0: blen = blen + 1;
            1: blen = blen - 1;
            2: ext[$urandom_range(0, dims - 1)] = 0;
            3: dims = $urandom_range(0, 1) ? 0 : $urandom_range(5, 7);
            4: side = 0;
            5: tsize = 0;
            default: ;
        endcase
        cfg_words[REG_DIM_COUNT] = dims;
        cfg_words[REG_CELL_SIDE] = side;
        cfg_words[REG_TYPE_SIZE] = tsize;
        cfg_words[REG_EXTENT_0] = ext[0];
        cfg_words[REG_EXTENT_1] = ext[1];
        cfg_words[REG_EXTENT_2] = ext[2];
        cfg_words[REG_EXTENT_3] = ext[3];
        cfg_words[REG_BLOCK_BYTES] = blen;
        // Now and then, junk in the bits above each register.
        if ($urandom_range(0, 4) == 0)
            for (d = 0; d < 8; d++)
                cfg_words[d] = cfg_words[d] | ($urandom() & ~keep[d]);
        program_regs();
    endtask

    // One request transfer, with an optional idle burst in front of it.
    task automatic send_request(bit restart);
        if (tx_idle_en && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(S_DATA_W-1){1'b0}}, restart};
        do @(posedge clk); while (!s_tready);
        runs.note_request(restart);
    endtask

    task automatic send_runs(int count, int restart_pct);
        int k;
        for (k = 0; k < count; k++)
            send_request($urandom_range(0, 99) < restart_pct);
        s_tvalid <= 1'b0;
    endtask

    initial
    begin
        int phase;
        int restart_pct;
        int k;
        runs = new();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        hold_req = 1'b0;
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset geometry: a continue with no walk behaves as a restart.
        send_request(1'b0);
        send_request(1'b1);
        s_tvalid <= 1'b0;

        // Each geometry error in turn.
        set_cfg(0, 1, 1, 1, 1, 1, 1, 1);
        send_runs(1, 0);
        set_cfg(7, 1, 1, 1, 1, 1, 1, 1);
        send_runs(1, 0);
        set_cfg(1, 0, 1, 1, 1, 1, 1, 1);
        send_runs(1, 0);
        set_cfg(1, 1, 0, 1, 1, 1, 1, 1);
        send_runs(1, 0);
        set_cfg(3, 1, 1, 2, 0, 2, 1, 4);
        send_runs(1, 0);
        set_cfg(2, 1, 1, 100, 100, 1, 1, 50);
        send_runs(1, 0);
        set_cfg(2, 1, 1, 3, 5, 1, 1, 32'h7FFF_FFFF);
        send_runs(1, 0);
        set_cfg(2, 4, 1, 2, 2, 1, 1, 4);
        send_runs(1, 0);

        // Largest fields in valid geometries.
        set_cfg(1, 255, 255, 65535, 1, 1, 1, 16711425);
        send_runs(2, 0);
        set_cfg(2, 255, 1, 32768, 65535, 65535, 65535, 32'h7FFF_8000);
        send_runs(2, 0);

        // A walk through clipped edge cells, with a restart inside it.
        set_cfg(2, 2, 3, 3, 5, 1, 1, 45);
        for (k = 0; k < 10; k++)
            send_request(k == 3);
        s_tvalid <= 1'b0;

        // Random geometries; the last phases run without idling.
        for (phase = 0; phase < 20; phase++)
        begin
            tx_idle_en = (phase < 16) && (phase != 2) && ($urandom_range(0, 3) != 0);
            rx_idle_en = (phase < 16) && ($urandom_range(0, 3) != 0);
            pick_random_geometry();
            if (phase == 2)
                hold_req = 1'b1;
            case ($urandom_range(0, 2))
                0: restart_pct = 0;
                1: restart_pct = 4;
                default: restart_pct = 15;
            endcase
            send_runs(48, restart_pct);
        end

        while (runs.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (runs.mismatches == 0)
            $display("nd_cell_tiling_address_gen regression: pass");
        else
            $display("nd_cell_tiling_address_gen regression: fail");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/ctag_pkg.sv
rtl/ctag_geom.sv
rtl/nd_cell_tiling_address_gen.sv
rtl/ctag_checker.sv
bench/tb_nd_cell_tiling_address_gen.sv
